// ----- sv/icl8259_pkg.sv -----
// Shared types and codes for the interrupt controller.
// Depends on nothing; every other file in the block imports it.
`default_nettype none

package icl8259_pkg;

    localparam int unsigned InDataW  = 16;  // action, value, irq packed, padded to bytes
    localparam int unsigned OutDataW = 16;  // read_data, vector

    // Action codes carried in the low bits of an input word
    localparam logic [2:0] ACT_WRITE_CMD  = 3'd0;
    localparam logic [2:0] ACT_READ_STAT  = 3'd1;
    localparam logic [2:0] ACT_WRITE_DATA = 3'd2;
    localparam logic [2:0] ACT_READ_MASK  = 3'd3;
    localparam logic [2:0] ACT_REQUEST    = 3'd4;
    localparam logic [2:0] ACT_ACK        = 3'd5;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] value;
        logic [2:0] irq;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] vector;
        logic       vector_valid;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/interrupt_controller_8259_lite.sv -----
// Simplified 8259-style interrupt controller. Each word on the slave stream is one
// action (command write, status read, data write, mask read, IRQ request or
// acknowledge) and produces exactly one word on the master stream, in order. A word
// is registered on entry, applied to the controller state by a combinational update
// and the answer is captured in the output register, which presents it to the sink;
// one word is taken per cycle for as long as the sink keeps i_m_axis_tready high. The
// output register is the only thing that stalls the path.
`default_nettype none

module interrupt_controller_8259_lite (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [2:0] action, [10:3] value, [13:11] irq, [15:14] zero
    input  wire logic [icl8259_pkg::InDataW-1:0]   i_s_axis_tdata,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [7:0] read_data, [15:8] vector
    output logic [icl8259_pkg::OutDataW-1:0]       o_m_axis_tdata,
    // [0] vector_valid
    output logic                                   o_m_axis_tuser
);
    import icl8259_pkg::*;

    logic    w_free;
    logic    w_item_valid;
    logic    w_load;
    t_item   w_item;
    t_result w_result;

    assign w_load = w_item_valid && w_free;

    icl8259_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_advance       (w_free),
        .o_valid         (w_item_valid),
        .o_item          (w_item)
    );

    icl8259_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_load),
        .i_item   (w_item),
        .o_result (w_result)
    );

    icl8259_out_reg u_out_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_load),
        .i_result        (w_result),
        .o_free          (w_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // A granted acknowledge never carries status or mask data
    a_ack_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata[7:0] == 8'd0)
        else $error("acknowledge word carries read data");

    // A word applied to the core is presented on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_m_axis_tvalid)
        else $error("applied word did not reach the output register");

    // An empty output side must never block the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled while output is empty");

endmodule

`default_nettype wire

// ----- sv/icl8259_in_reg.sv -----
// Input register: takes one word from the slave stream and holds it for the core.
// Depends on icl8259_pkg.
`default_nettype none

module icl8259_in_reg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [icl8259_pkg::InDataW-1:0]   i_s_axis_tdata,
    input  wire logic                              i_advance,
    output logic                                   o_valid,
    output icl8259_pkg::t_item                     o_item
);
    import icl8259_pkg::*;

    logic  r_valid;
    t_item r_item;

    // Empty stage, or the held word moves on this cycle
    assign o_s_axis_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.action <= i_s_axis_tdata[2:0];
            r_item.value  <= i_s_axis_tdata[10:3];
            r_item.irq    <= i_s_axis_tdata[13:11];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- sv/icl8259_core.sv -----
// Controller state (init sequence, IRR, ISR, mask, vector base) and the
// single-pass update for one action. Depends on icl8259_pkg.
`default_nettype none

module icl8259_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire icl8259_pkg::t_item    i_item,
    output icl8259_pkg::t_result       o_result
);
    import icl8259_pkg::*;

    // Initialisation sequence
    localparam logic [2:0] STEP_ICW1 = 3'd1;
    localparam logic [2:0] STEP_ICW2 = 3'd2;
    localparam logic [2:0] STEP_ICW3 = 3'd3;
    localparam logic [2:0] STEP_ICW4 = 3'd4;
    localparam logic [2:0] STEP_RUN  = 3'd5;

    logic [2:0] r_step,     n_step;
    logic       r_need4,    n_need4;
    logic       r_isr_sel,  n_isr_sel;
    logic [7:0] r_isr,      n_isr;
    logic [7:0] r_irr,      n_irr;
    logic [7:0] r_mask,     n_mask;
    logic [4:0] r_base,     n_base;

    logic       w_found;
    logic [2:0] w_idx;

    // Lowest pending line wins
    always_comb begin
        w_found = 1'b0;
        w_idx   = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (r_irr[i]) begin
                w_found = 1'b1;
                w_idx   = 3'(i);
            end
        end
    end

    always_comb begin
        n_step    = r_step;
        n_need4   = r_need4;
        n_isr_sel = r_isr_sel;
        n_isr     = r_isr;
        n_irr     = r_irr;
        n_mask    = r_mask;
        n_base    = r_base;
        o_result  = '0;
        case (i_item.action)
            ACT_WRITE_CMD: begin
                if (r_step == STEP_ICW1) begin
                    n_need4 = r_need4 | i_item.value[0];
                    n_step  = STEP_ICW2;
                end else if (i_item.value[3]) begin
                    if (i_item.value[1:0] == 2'b10) begin
                        n_isr_sel = 1'b0;
                    end else if (i_item.value[1:0] == 2'b11) begin
                        n_isr_sel = 1'b1;
                    end
                end else if (i_item.value[5]) begin
                    n_isr[i_item.value[2:0]] = 1'b0;
                end
            end
            ACT_READ_STAT: begin
                o_result.read_data = r_isr_sel ? r_isr : r_irr;
            end
            ACT_WRITE_DATA: begin
                if (r_step == STEP_ICW2) begin
                    n_base = i_item.value[7:3];
                    n_step = STEP_ICW3;
                end else if (r_step == STEP_ICW3) begin
                    n_step = STEP_ICW4;
                end else if (r_step == STEP_ICW4 && r_need4) begin
                    n_need4 = 1'b0;
                    n_step  = STEP_RUN;
                end else if (!r_need4 && (r_step == STEP_ICW4 || r_step == STEP_RUN)) begin
                    n_mask = i_item.value;
                end
            end
            ACT_READ_MASK: begin
                o_result.read_data = r_mask;
            end
            ACT_REQUEST: begin
                if (!r_mask[i_item.irq]) begin
                    n_irr[i_item.irq] = 1'b1;
                end
            end
            ACT_ACK: begin
                if (w_found) begin
                    n_irr[w_idx]          = 1'b0;
                    n_isr[w_idx]          = 1'b1;
                    o_result.vector       = {r_base, w_idx};
                    o_result.vector_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_ICW1;
            r_need4   <= 1'b0;
            r_isr_sel <= 1'b0;
            r_isr     <= '0;
            r_irr     <= '0;
            r_mask    <= '0;
            r_base    <= '0;
        end else if (i_fire) begin
            r_step    <= n_step;
            r_need4   <= n_need4;
            r_isr_sel <= n_isr_sel;
            r_isr     <= n_isr;
            r_irr     <= n_irr;
            r_mask    <= n_mask;
            r_base    <= n_base;
        end
    end

endmodule

`default_nettype wire

// ----- sv/icl8259_out_reg.sv -----
// Result register on the master stream: holds a word until the sink takes it.
// Depends on icl8259_pkg.
`default_nettype none

module icl8259_out_reg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_load,
    input  wire icl8259_pkg::t_result              i_result,
    output logic                                   o_free,
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [icl8259_pkg::OutDataW-1:0]       o_m_axis_tdata,
    output logic                                   o_m_axis_tuser
);
    import icl8259_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Room for a new word when empty or the held one leaves now
    assign o_free = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {r_result.vector, r_result.read_data};
    assign o_m_axis_tuser  = r_result.vector_valid;

endmodule

`default_nettype wire
